@@ hw/rtl/ffba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
    // byte-position width covering the whole arena range plus header and block size
    localparam int SW = 18;
    localparam int OFF_W = 10;

    localparam int ARENA_BYTES_DEF = 1024;
    localparam int GRANULE_BYTES_DEF = 16;
    localparam int HEADER_BYTES_DEF = 16;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic active;
        logic op;
        logic ok;
        logic split;
        logic [SW-1:0] req;
        logic [SW-1:0] start;
        logic [SW-1:0] tail_start;
        logic [SW-1:0] tail_bytes;
        logic [OFF_W-1:0] res_off;
    } ffba_token_t;
endpackage
`default_nettype wire

@@ hw/rtl/ffba_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ffba_cell #(
    parameter int IDX = 0,
    parameter int ARENA_BYTES = ffba_pkg::ARENA_BYTES_DEF,
    parameter int GRANULE_BYTES = ffba_pkg::GRANULE_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  ffba_pkg::ffba_token_t tok_in,
    output ffba_pkg::ffba_token_t tok_out
);
    localparam int SW = ffba_pkg::SW;
    localparam int NG = ARENA_BYTES / GRANULE_BYTES;
    localparam int PH_I = ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
    localparam int INIT_I = (ARENA_BYTES > PH_I) ? ARENA_BYTES - PH_I : 0;
    localparam int BW = $clog2(ARENA_BYTES + 1);
    localparam logic [SW-1:0] PH = SW'(PH_I);
    localparam logic [SW-1:0] GR = SW'(GRANULE_BYTES);
    localparam logic [SW-1:0] LO = SW'(IDX * GRANULE_BYTES);
    localparam logic [SW-1:0] HI = SW'((IDX + 1) * GRANULE_BYTES);
    localparam logic [SW-1:0] END_POS = SW'(NG * GRANULE_BYTES);

    logic starts_reg, starts_next;
    logic used_reg, used_next;
    logic [BW-1:0] bytes_reg, bytes_next;
    ffba_pkg::ffba_token_t tok_reg, tok_next;

    logic [SW-1:0] bytes_ext, need_bytes, tail_pos;
    logic start_hit, tail_hit;

    always_comb begin
        bytes_ext = SW'(bytes_reg);
        need_bytes = tok_in.req + PH;
        tail_pos = tok_in.start + need_bytes;
        start_hit = (tok_in.start >= LO) && (tok_in.start < HI);
        tail_hit = (tok_in.tail_start >= LO) && (tok_in.tail_start < HI);
        starts_next = starts_reg;
        used_next = used_reg;
        bytes_next = bytes_reg;
        tok_next = tok_in;
        if (tok_in.active) begin
            if (tok_in.op == ffba_pkg::ACT_ALLOC) begin
                if (tok_in.split && tail_hit) begin
                    starts_next = 1'b1;
                    bytes_next = BW'(tok_in.tail_bytes);
                    used_next = 1'b0;
                    tok_next.split = 1'b0;
                end
                if (!tok_in.ok && start_hit) begin
                    if (!used_reg && bytes_ext >= tok_in.req) begin
                        tok_next.ok = 1'b1;
                        tok_next.res_off = ffba_pkg::OFF_W'(tok_in.start + PH);
                        used_next = 1'b1;
                        if (bytes_ext >= need_bytes + GR && tail_pos < END_POS) begin
                            tok_next.split = 1'b1;
                            tok_next.tail_start = tail_pos;
                            tok_next.tail_bytes = bytes_ext - need_bytes;
                            bytes_next = BW'(tok_in.req);
                        end
                    end else begin
                        tok_next.start = tok_in.start + PH + bytes_ext;
                    end
                end
            end else begin
                if (tok_in.start == LO && starts_reg) begin
                    used_next = 1'b0;
                    tok_next.ok = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            starts_reg <= (IDX == 0);
            used_reg <= 1'b0;
            bytes_reg <= (IDX == 0) ? BW'(INIT_I) : '0;
            tok_reg <= '0;
        end else begin
            starts_reg <= starts_next;
            used_reg <= used_next;
            bytes_reg <= bytes_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
endmodule
`default_nettype wire

@@ hw/rtl/first_fit_block_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// First-fit block allocator. One transfer in, one result transfer out. Each
// item is processed in order: the amount is rounded up to whole granules as
// it is accepted, a request token walks the row of per-granule cells one cell
// per cycle, and the result is captured and then registered for output. One
// item is in flight at a time; a new item is taken while the previous result
// still waits on the output. Reset restores the arena to one free block
// immediately, with no clearing pass.
module first_fit_block_allocator_core #(
    parameter int ARENA_BYTES = ffba_pkg::ARENA_BYTES_DEF,
    parameter int GRANULE_BYTES = ffba_pkg::GRANULE_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // amount[9:0], payload_offset[19:10]
    input  wire         s_tuser,   // action
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // result_offset[9:0], status[11:10]
);
    localparam int SW = ffba_pkg::SW;
    localparam int OW = ffba_pkg::OFF_W;
    localparam int NG = ARENA_BYTES / GRANULE_BYTES;
    localparam int PH_I = ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
    localparam logic [SW-1:0] PH = SW'(PH_I);
    localparam int RK = 24;
    localparam int RECIP_I = ((1 << RK) + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int PW = RK + 12;
    localparam logic [PW-1:0] RECIP = PW'(RECIP_I);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_RUN  = 4'b0100,
        S_HOLD = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic op_reg;
    logic [OW-1:0] off_reg;
    logic [PW-1:0] prod_reg;
    ffba_pkg::ffba_token_t done_reg;
    logic m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [OW:0] amt_up;
    logic [SW-1:0] req_g;

    ffba_pkg::ffba_token_t tok [0:NG];

    assign s_tready = (state_reg == S_IDLE);
    assign amt_up = {1'b0, s_tdata[OW-1:0]} + (OW+1)'(GRANULE_BYTES - 1);
    assign req_g = SW'(prod_reg >> RK) * SW'(GRANULE_BYTES);

    always_comb begin
        tok[0] = '0;
        if (state_reg == S_PREP) begin
            tok[0].active = 1'b1;
            tok[0].op = op_reg;
            if (op_reg == ffba_pkg::ACT_ALLOC) begin
                tok[0].start = '0;
                tok[0].req = req_g;
            end else begin
                tok[0].start = (SW'(off_reg) >= PH) ? SW'(off_reg) - PH : '1;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NG; gi++) begin : g_cell
            ffba_cell #(
                .IDX(gi),
                .ARENA_BYTES(ARENA_BYTES),
                .GRANULE_BYTES(GRANULE_BYTES),
                .HEADER_BYTES(HEADER_BYTES)
            ) u_cell (
                .aclk(aclk),
                .aresetn(aresetn),
                .tok_in(tok[gi]),
                .tok_out(tok[gi+1])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_PREP;
            S_PREP: state_next = S_RUN;
            S_RUN:  if (tok[NG].active) state_next = S_HOLD;
            S_HOLD: if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_HOLD && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= s_tuser;
            off_reg <= s_tdata[2*OW-1:OW];
            prod_reg <= PW'(amt_up) * RECIP;
        end
        if (state_reg == S_RUN && tok[NG].active) begin
            done_reg <= tok[NG];
        end
        if (state_reg == S_HOLD && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg[15:12] <= '0;
            if (done_reg.op == ffba_pkg::ACT_ALLOC) begin
                m_tdata_reg[OW-1:0] <= done_reg.ok ? done_reg.res_off : '0;
                m_tdata_reg[11:10] <= done_reg.ok ? ffba_pkg::ST_OK : ffba_pkg::ST_NO_FIT;
            end else begin
                m_tdata_reg[OW-1:0] <= '0;
                m_tdata_reg[11:10] <= done_reg.ok ? ffba_pkg::ST_OK : ffba_pkg::ST_BAD_FREE;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

`ifndef SYNTHESIS
    a_token_exit_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[NG].active |-> state_reg == S_RUN)
        else $error("token left the cell row outside the run phase");
    a_accept_starts_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_PREP)
        else $error("accepted transfer did not start a request");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:10] != 2'd3)
        else $error("undefined status code");
    a_bad_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11:10] != ffba_pkg::ST_OK |-> m_tdata[9:0] == '0)
        else $error("nonzero offset with error status");
`endif
endmodule
`default_nettype wire
